// ===== src/quoted_field_splitter_top_defines.svh =====
// ----------------------------------------------------------------------------
// quoted field splitter assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef QUOTED_FIELD_SPLITTER_TOP_DEFINES_SVH
`define QUOTED_FIELD_SPLITTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define QFS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("qfs check failed");
// next-cycle implication
`define QFS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("qfs check failed");
`else
`define QFS_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define QFS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== src/qfs_pkg.sv =====
// ----------------------------------------------------------------------------
// qfs_pkg
// shared types and constants of the quoted field splitter
// ----------------------------------------------------------------------------
package qfs_pkg;

  localparam int MAX_RESULTS = 3;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FEND = 2'd1;
  localparam logic [1:0] KIND_SEND = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MAX_FIELDS   = 3'd0;
  localparam logic [2:0] REG_DELIM_LOW    = 3'd1;
  localparam logic [2:0] REG_DELIM_MID_LO = 3'd2;
  localparam logic [2:0] REG_DELIM_MID_HI = 3'd3;
  localparam logic [2:0] REG_DELIM_HIGH   = 3'd4;

  localparam logic [7:0]  MAX_FIELDS_RESET = 8'd255;
  localparam logic [63:0] DELIM_LOW_RESET  = 64'h0000_1000_0000_0000;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5c;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_7     = 8'h37;
  localparam logic [7:0] CHAR_LC_B  = 8'h62;
  localparam logic [7:0] CHAR_LC_N  = 8'h6e;
  localparam logic [7:0] CHAR_LC_R  = 8'h72;
  localparam logic [7:0] CHAR_LC_T  = 8'h74;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] count;
  } result_t;

  typedef struct packed {
    logic [1:0]                        cnt;
    result_t [MAX_RESULTS-1:0]         res;
  } bundle_t;

  function automatic result_t make_res(logic [1:0] kind, logic [7:0] data,
                                       logic [7:0] index, logic [7:0] count);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.index = index;
    r.count = count;
    return r;
  endfunction

endpackage

// ===== src/quoted_field_splitter_top.sv =====
// ----------------------------------------------------------------------------
// quoted_field_splitter_top
// splits a NUL-ended byte stream into quoted, escaped fields
// ----------------------------------------------------------------------------
//   channel  | signals                                         | role
//   ---------+-------------------------------------------------+---------------
//   in       | in_valid, in_stall, in_byte                     | one byte
//   out      | out_valid, out_stall, out_kind, out_byte,       | one result
//            | field_index, field_count, last                  |
//   cfg      | cfg_we, cfg_index, cfg_data                     | register write
//
// a byte is parsed in the cycle it is accepted; its zero to three results are
// held in a result register and leave one per cycle while out_stall is low.
// a new byte is taken in the cycle the last held result is taken, or at once
// when no result is held.
// reset restores the register defaults and the start-of-string state.
// ----------------------------------------------------------------------------
`include "quoted_field_splitter_top_defines.svh"

module quoted_field_splitter_top import qfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  field_index,
  output logic [7:0]  field_count,
  output logic        last
);

  bundle_t                   bundle;
  result_t [MAX_RESULTS-1:0] res_q;
  logic [1:0]                cnt_q;
  logic [1:0]                head_q;
  logic                      take;
  logic                      pop;
  logic                      pop_last;
  result_t                   cur;

  qfs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_byte   (in_byte),
    .bundle    (bundle)
  );

  assign cur         = res_q[head_q];
  assign out_valid   = (cnt_q != 2'd0);
  assign pop         = out_valid && !out_stall;
  assign pop_last    = (head_q == cnt_q - 2'd1);
  assign in_stall    = out_valid && !(pop && pop_last);
  assign take        = in_valid && !in_stall;

  assign out_kind    = cur.kind;
  assign out_byte    = cur.data;
  assign field_index = cur.index;
  assign field_count = cur.count;
  assign last        = pop_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else if (take && bundle.cnt != 2'd0) begin
      res_q  <= bundle.res;
      cnt_q  <= bundle.cnt;
      head_q <= '0;
    end else if (pop) begin
      if (pop_last) begin
        cnt_q  <= '0;
        head_q <= '0;
      end else begin
        head_q <= head_q + 2'd1;
      end
    end
  end

  `QFS_ASSERT_NOW(a_head_in_range, clk, rst, cnt_q != 2'd0, head_q < cnt_q)
  `QFS_ASSERT_NOW(a_send_is_last, clk, rst, out_valid && out_kind == KIND_SEND,
                  last && field_count == field_index + 8'd1)
  `QFS_ASSERT_NOW(a_err_is_last, clk, rst, out_valid && out_kind == KIND_ERR, last)
  `QFS_ASSERT_NEXT(a_pop_advances, clk, rst, pop && !pop_last && !take,
                   out_valid && head_q == $past(head_q) + 2'd1)

endmodule

// ===== src/qfs_parser.sv =====
// ----------------------------------------------------------------------------
// qfs_parser
// configuration registers, parse state and the per-byte result bundle
// ----------------------------------------------------------------------------
module qfs_parser import qfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        take,
  input  logic [7:0]  in_byte,
  output bundle_t     bundle
);

  logic [7:0]   max_fields;
  logic [255:0] delim_map;

  logic       at_field_start, at_field_start_next;
  logic       inside_quotes, inside_quotes_next;
  logic       escape_pending, escape_pending_next;
  logic       octal_active, octal_active_next;
  logic [7:0] octal_value, octal_value_next;
  logic [7:0] current_field, current_field_next;
  logic       string_started, string_started_next;
  logic       discarding, discarding_next;

  logic       done;
  logic       is_octal;
  logic       is_delim;
  logic [7:0] esc_byte;
  logic [1:0] n;

  assign is_octal = (in_byte >= CHAR_0) && (in_byte <= CHAR_7);
  assign is_delim = (in_byte != CHAR_NUL) && delim_map[in_byte];

  always_comb begin
    case (in_byte)
      CHAR_LC_B: esc_byte = CHAR_BS;
      CHAR_LC_N: esc_byte = CHAR_LF;
      CHAR_LC_R: esc_byte = CHAR_CR;
      CHAR_LC_T: esc_byte = CHAR_TAB;
      default:   esc_byte = in_byte;
    endcase
  end

  always_comb begin
    at_field_start_next = at_field_start;
    inside_quotes_next  = inside_quotes;
    escape_pending_next = escape_pending;
    octal_active_next   = octal_active;
    octal_value_next    = octal_value;
    current_field_next  = current_field;
    string_started_next = string_started;
    discarding_next     = discarding;
    bundle              = '0;
    n                   = 2'd0;
    done                = 1'b0;

    if (discarding) begin
      done = 1'b1;
      if (in_byte == CHAR_NUL) begin
        at_field_start_next = 1'b1;
        inside_quotes_next  = 1'b0;
        escape_pending_next = 1'b0;
        octal_active_next   = 1'b0;
        octal_value_next    = '0;
        current_field_next  = '0;
        string_started_next = 1'b0;
        discarding_next     = 1'b0;
      end
    end

    // limit check on the first byte of a string
    if (!done && !string_started) begin
      string_started_next = 1'b1;
      if (current_field >= max_fields) begin
        bundle.res[n] = make_res(KIND_ERR, 8'd0, current_field, 8'd0);
        n = n + 2'd1;
        done = 1'b1;
        if (in_byte == CHAR_NUL) begin
          string_started_next = 1'b0;
        end else begin
          discarding_next = 1'b1;
        end
      end
    end

    if (!done && escape_pending) begin
      done = 1'b1;
      escape_pending_next = 1'b0;
      if (in_byte == CHAR_NUL) begin
        bundle.res[n] = make_res(KIND_SEND, 8'd0, current_field, current_field + 8'd1);
        n = n + 2'd1;
        at_field_start_next = 1'b1;
        inside_quotes_next  = 1'b0;
        octal_active_next   = 1'b0;
        octal_value_next    = '0;
        current_field_next  = '0;
        string_started_next = 1'b0;
      end else if (is_octal) begin
        octal_active_next = 1'b1;
        octal_value_next  = {5'd0, in_byte[2:0]};
      end else begin
        bundle.res[n] = make_res(KIND_DATA, esc_byte, current_field, 8'd0);
        n = n + 2'd1;
      end
    end

    if (!done && octal_active) begin
      if (is_octal) begin
        done = 1'b1;
        octal_value_next = {octal_value[4:0], in_byte[2:0]};
      end else begin
        // octal run ends: flush the value, then handle this byte normally
        bundle.res[n] = make_res(KIND_DATA, octal_value, current_field, 8'd0);
        n = n + 2'd1;
        octal_active_next = 1'b0;
        octal_value_next  = '0;
      end
    end

    if (!done && at_field_start && (in_byte == CHAR_SPACE || in_byte == CHAR_TAB)) begin
      done = 1'b1;
    end

    if (!done) begin
      at_field_start_next = 1'b0;
      if (in_byte == CHAR_NUL) begin
        bundle.res[n] = make_res(KIND_SEND, 8'd0, current_field, current_field + 8'd1);
        n = n + 2'd1;
        at_field_start_next = 1'b1;
        inside_quotes_next  = 1'b0;
        escape_pending_next = 1'b0;
        octal_active_next   = 1'b0;
        octal_value_next    = '0;
        current_field_next  = '0;
        string_started_next = 1'b0;
        discarding_next     = 1'b0;
      end else if (is_delim) begin
        if (inside_quotes) begin
          bundle.res[n] = make_res(KIND_DATA, in_byte, current_field, 8'd0);
          n = n + 2'd1;
        end else begin
          bundle.res[n] = make_res(KIND_FEND, 8'd0, current_field, 8'd0);
          n = n + 2'd1;
          current_field_next  = current_field + 8'd1;
          at_field_start_next = 1'b1;
          inside_quotes_next  = 1'b0;
          if (current_field_next >= max_fields) begin
            bundle.res[n] = make_res(KIND_ERR, 8'd0, current_field_next, 8'd0);
            n = n + 2'd1;
            discarding_next = 1'b1;
          end
        end
      end else if (in_byte == CHAR_QUOTE) begin
        inside_quotes_next = !inside_quotes;
      end else if (in_byte == CHAR_BSL) begin
        escape_pending_next = 1'b1;
      end else begin
        bundle.res[n] = make_res(KIND_DATA, in_byte, current_field, 8'd0);
        n = n + 2'd1;
      end
    end

    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields     <= MAX_FIELDS_RESET;
      delim_map      <= {192'd0, DELIM_LOW_RESET};
      at_field_start <= 1'b1;
      inside_quotes  <= 1'b0;
      escape_pending <= 1'b0;
      octal_active   <= 1'b0;
      octal_value    <= '0;
      current_field  <= '0;
      string_started <= 1'b0;
      discarding     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_FIELDS:   max_fields <= cfg_data[7:0];
          REG_DELIM_LOW:    delim_map[63:0]    <= cfg_data;
          REG_DELIM_MID_LO: delim_map[127:64]  <= cfg_data;
          REG_DELIM_MID_HI: delim_map[191:128] <= cfg_data;
          REG_DELIM_HIGH:   delim_map[255:192] <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        at_field_start <= at_field_start_next;
        inside_quotes  <= inside_quotes_next;
        escape_pending <= escape_pending_next;
        octal_active   <= octal_active_next;
        octal_value    <= octal_value_next;
        current_field  <= current_field_next;
        string_started <= string_started_next;
        discarding     <= discarding_next;
      end
    end
  end

endmodule

// ===== bench/field_split_checker.sv =====
// ----------------------------------------------------------------------------
// field_split_checker
// watches the byte, result and register ports of the field splitter, predicts
// the tokens each accepted byte yields and compares them in order
// ----------------------------------------------------------------------------
module field_split_checker import qfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic [7:0]  field_index,
  input  logic [7:0]  field_count,
  input  logic        last,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] count;
    logic       last;
  } token_t;

  // register copies
  logic [7:0]   field_limit;
  logic [255:0] delim_set;

  // parser state
  bit         field_start;
  bit         quoted;
  bit         escaped;
  bit         octal_on;
  logic [7:0] octal_acc;
  logic [7:0] field_no;
  bit         started;
  bit         discard;

  token_t byte_tokens[$];
  token_t due_tokens[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_string();
    field_start = 1'b1;
    quoted = 1'b0;
    escaped = 1'b0;
    octal_on = 1'b0;
    octal_acc = '0;
    field_no = '0;
    started = 1'b0;
    discard = 1'b0;
  endtask

  task automatic add_token(input logic [1:0] kind, input logic [7:0] data,
                           input logic [7:0] count);
    token_t t;
    t.kind = kind;
    t.data = data;
    t.index = field_no;
    t.count = count;
    t.last = 1'b0;
    byte_tokens.push_back(t);
  endtask

  task automatic end_string();
    add_token(KIND_SEND, 8'd0, field_no + 8'd1);
    clear_string();
  endtask

  task automatic limit_check(input logic [7:0] c);
    if (field_no >= field_limit) begin
      add_token(KIND_ERR, 8'd0, 8'd0);
      if (c == CHAR_NUL) clear_string();
      else discard = 1'b1;
    end
  endtask

  // tokens caused by one source byte, in order, into byte_tokens
  task automatic split_byte(input logic [7:0] c);
    logic [7:0] v;
    if (discard) begin
      if (c == CHAR_NUL) clear_string();
      return;
    end
    if (!started) begin
      started = 1'b1;
      limit_check(c);
      if (byte_tokens.size() > 0) return;
    end
    if (escaped) begin
      escaped = 1'b0;
      if (c == CHAR_NUL) begin
        end_string();
      end else if (c >= CHAR_0 && c <= CHAR_7) begin
        octal_on = 1'b1;
        octal_acc = {5'd0, c[2:0]};
      end else begin
        case (c)
          CHAR_LC_B: v = CHAR_BS;
          CHAR_LC_N: v = CHAR_LF;
          CHAR_LC_R: v = CHAR_CR;
          CHAR_LC_T: v = CHAR_TAB;
          default:   v = c;
        endcase
        add_token(KIND_DATA, v, 8'd0);
      end
      return;
    end
    if (octal_on) begin
      if (c >= CHAR_0 && c <= CHAR_7) begin
        octal_acc = {octal_acc[4:0], c[2:0]};
        return;
      end
      add_token(KIND_DATA, octal_acc, 8'd0);
      octal_on = 1'b0;
      octal_acc = '0;
    end
    if (field_start && (c == CHAR_SPACE || c == CHAR_TAB)) return;
    field_start = 1'b0;

    if (c == CHAR_NUL) begin
      end_string();
    end else if (delim_set[c]) begin
      if (quoted) begin
        add_token(KIND_DATA, c, 8'd0);
      end else begin
        add_token(KIND_FEND, 8'd0, 8'd0);
        field_no = field_no + 8'd1;
        field_start = 1'b1;
        quoted = 1'b0;
        limit_check(c);
      end
    end else if (c == CHAR_QUOTE) begin
      quoted = !quoted;
    end else if (c == CHAR_BSL) begin
      escaped = 1'b1;
    end else begin
      add_token(KIND_DATA, c, 8'd0);
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      field_limit = MAX_FIELDS_RESET;
      delim_set = {192'd0, DELIM_LOW_RESET};
      clear_string();
      due_tokens.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d index %0d",
                                    out_kind, field_index));
        end else begin
          want = due_tokens.pop_front();
          check_field("kind", 8'(out_kind), 8'(want.kind));
          check_field("byte", out_byte, want.data);
          check_field("field_index", field_index, want.index);
          check_field("field_count", field_count, want.count);
          check_field("last", 8'(last), 8'(want.last));
        end
      end
      // a byte taken with a register write still sees the old setting
      if (in_valid && !in_stall) begin
        byte_tokens.delete();
        split_byte(in_byte);
        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i]) due_tokens.push_back(byte_tokens[i]);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FIELDS:   field_limit = cfg_data[7:0];
          REG_DELIM_LOW:    delim_set[63:0] = cfg_data;
          REG_DELIM_MID_LO: delim_set[127:64] = cfg_data;
          REG_DELIM_MID_HI: delim_set[191:128] = cfg_data;
          REG_DELIM_HIGH:   delim_set[255:192] = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= due_tokens.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives NUL-ended strings through the field splitter under several delimiter
// sets and field limits, with random source gaps and sink stalls
// ----------------------------------------------------------------------------
module testbench import qfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 170;
  localparam int MIN_PHASES    = 5;
  localparam int CYCLE_LIMIT   = 150000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 6;

  localparam logic [2:0] REG_SPARE  = 3'd7;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  field_index;
  logic [7:0]  field_count;
  logic        last;

  int mismatches;
  int pending;
  int cycles = 0;
  int bytes_sent = 0;
  int gap_max = 4;
  int stall_max = 4;
  int phase;
  bit hold_req = 1'b0;

  logic [255:0] delim_mirror = {192'd0, DELIM_LOW_RESET};
  logic [7:0]   line_bytes[$];

  quoted_field_splitter_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .field_index (field_index),
    .field_count (field_count),
    .last        (last)
  );

  field_split_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .field_index (field_index),
    .field_count (field_count),
    .last        (last),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result sink: random stall per result, one long hold-off on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_DELIM_LOW:    delim_mirror[63:0] = value;
      REG_DELIM_MID_LO: delim_mirror[127:64] = value;
      REG_DELIM_MID_HI: delim_mirror[191:128] = value;
      REG_DELIM_HIGH:   delim_mirror[255:192] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits of the limit write are don't-care, so fill them randomly
  task automatic load_config(input logic [7:0] limit, input logic [63:0] m0,
                             input logic [63:0] m1, input logic [63:0] m2,
                             input logic [63:0] m3);
    write_reg(REG_MAX_FIELDS, {$urandom, 24'($urandom), limit});
    write_reg(REG_DELIM_LOW, m0);
    write_reg(REG_DELIM_MID_LO, m1);
    write_reg(REG_DELIM_MID_HI, m2);
    write_reg(REG_DELIM_HIGH, m3);
  endtask

  // drop valid and let every pending result and any silent byte drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return CHAR_LC_A + 8'($urandom_range(0, 25));
  endfunction

  // a byte from the current delimiter set, or plain text if none is found
  function automatic logic [7:0] pick_delim();
    logic [7:0] c;
    for (int k = 0; k < 32; k++) begin
      c = 8'($urandom_range(1, 255));
      if (delim_mirror[c]) return c;
    end
    return plain_char();
  endfunction

  task automatic add_piece();
    case ($urandom_range(0, 7))
      0, 1, 2: line_bytes.push_back(plain_char());
      3: begin
        line_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(1, 3))
          line_bytes.push_back($urandom_range(0, 1) ? pick_delim() : plain_char());
        if ($urandom_range(0, 9) != 0) line_bytes.push_back(CHAR_QUOTE);
      end
      4: begin
        line_bytes.push_back(CHAR_BSL);
        repeat ($urandom_range(1, 4))
          line_bytes.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
      end
      5: begin
        line_bytes.push_back(CHAR_BSL);
        case ($urandom_range(0, 3))
          0: line_bytes.push_back(CHAR_LC_B);
          1: line_bytes.push_back(CHAR_LC_N);
          2: line_bytes.push_back(CHAR_LC_R);
          default: line_bytes.push_back(CHAR_LC_T);
        endcase
      end
      6: begin
        line_bytes.push_back(CHAR_BSL);
        line_bytes.push_back(8'($urandom_range(1, 255)));
      end
      default: line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endcase
  endtask

  // mostly well-formed fields, sometimes cut short, sometimes plain noise
  task automatic send_string(input bit noise);
    int nf;
    bit cut;
    cut = 1'b0;
    if (noise) begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf && !cut; f++) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2))
            line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        repeat ($urandom_range(0, 4)) add_piece();
        if ($urandom_range(0, 9) == 0) begin
          cut = 1'b1;
          if ($urandom_range(0, 1)) line_bytes.push_back(CHAR_BSL);
        end else if (f < nf - 1) begin
          line_bytes.push_back(pick_delim());
        end
      end
    end
    line_bytes.push_back(CHAR_NUL);
    send_line();
  endtask

  initial begin
    logic [7:0] limit;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: blanks, quoted comma, escapes, octal ended by a
    // delimiter, trailing backslash, octal wrap, empty string
    line_bytes = '{CHAR_SPACE, CHAR_TAB, CHAR_QUOTE, CHAR_COMMA, CHAR_QUOTE,
                   CHAR_BSL, CHAR_LC_N, CHAR_BSL, CHAR_1, CHAR_0, CHAR_1,
                   CHAR_COMMA, CHAR_BSL, CHAR_NUL};
    send_line();
    line_bytes = '{CHAR_BSL, CHAR_LC_B, CHAR_BSL, CHAR_LC_R, CHAR_BSL, CHAR_LC_T,
                   CHAR_BSL, CHAR_7, CHAR_7, CHAR_7, CHAR_NUL};
    send_line();
    line_bytes = '{CHAR_NUL};
    send_line();

    // zero limit: error on a bare NUL, then error and discard
    settle();
    write_reg(REG_MAX_FIELDS, 64'd0);
    line_bytes = '{CHAR_NUL, CHAR_LC_A, CHAR_NUL};
    send_line();

    phase = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS || phase < MIN_PHASES) begin
      settle();
      case (phase % 5)
        0: begin
          limit = 8'($urandom_range(1, 6));
          load_config(limit, 64'd1 << CHAR_COMMA, 64'd0, 64'd0, 64'd0);
        end
        1: load_config(8'd3, '1, '1, '1, '1);
        2: begin
          if ($urandom_range(0, 3) == 0) limit = 8'($urandom_range(0, 255));
          else limit = 8'($urandom_range(1, 8));
          load_config(limit, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        end
        3: load_config(8'd255, (64'd1 << CHAR_COMMA) | (64'd1 << CHAR_SPACE) |
                       (64'd1 << CHAR_TAB) | (64'd1 << CHAR_QUOTE),
                       64'd1 << (CHAR_BSL - 8'd64), 64'd0, 64'd0);
        default: load_config(8'($urandom_range(2, 6)), '0, '0, '0, '0);
      endcase
      if (phase == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      gap_max = (phase % 4 == 2) ? 0 : 4;
      stall_max = (phase % 4 == 2) ? 0 : 4;
      // long sink hold-off while the source keeps pushing
      if (phase == 3) begin
        gap_max = 0;
        hold_req = 1'b1;
      end
      repeat (3) send_string($urandom_range(0, 4) == 0);
      phase++;
    end

    // field index runs up to the largest limit
    settle();
    load_config(8'd255, 64'd1 << CHAR_COMMA, 64'd0, 64'd0, 64'd0);
    gap_max = 1;
    stall_max = 1;
    repeat (256) line_bytes.push_back(CHAR_COMMA);
    line_bytes.push_back(CHAR_LC_A);
    line_bytes.push_back(CHAR_NUL);
    send_line();

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
